// ===== design/murmur3_x64_128_bucket_hash_macros.svh =====
// Assertion macros used by the checker file
`ifndef MURMUR3_X64_128_BUCKET_HASH_MACROS_SVH
`define MURMUR3_X64_128_BUCKET_HASH_MACROS_SVH

// Same-cycle implication, quiet during reset
`define MMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mmh assertion failed");

// Next-cycle implication, quiet during reset
`define MMH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mmh assertion failed");

`endif

// ===== design/mmh_pkg.sv =====
package mmh_pkg;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
        logic [4:0]  byte_count;
        logic        last_block;
    } t_in_word;

    typedef struct packed {
        logic [63:0] hash_low;
        logic [63:0] hash_high;
        logic [31:0] bucket_index;
        logic        length_overflow;
    } t_out_word;

    typedef enum logic [4:0] {
        U_NOP, U_W_K1, U_W_K2, U_MUL_A, U_MUL_B, U_MUL_FA, U_MUL_FB,
        U_ROT31, U_ROT33, U_H1_BODY, U_H1_FIN5, U_H2_BODY, U_H2_FIN5,
        U_H1_XOR, U_H2_XOR, U_LEN, U_ADD_AB, U_ADD_BA, U_W_H1, U_W_H2,
        U_SHX, U_H1_W, U_H2_W, U_DIV, U_RET, U_END
    } t_uop;

    typedef struct packed {
        logic load;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic unit_done;
        logic out_busy;
    } t_sts;

    localparam logic [63:0] C_MUL_A = 64'h87c37b91114253d5;
    localparam logic [63:0] C_MUL_B = 64'h4cf5ad432745937f;
    localparam logic [63:0] C_ADD_1 = 64'h0000000052dce729;
    localparam logic [63:0] C_ADD_2 = 64'h0000000038495ab5;
    localparam logic [63:0] C_FIN_A = 64'hff51afd7ed558ccd;
    localparam logic [63:0] C_FIN_B = 64'hc4ceb9fe1a85ec53;

    localparam logic [4:0] FULL_COUNT = 5'd16;
    localparam logic [6:0] MUL_LAST   = 7'd3;
    localparam logic [6:0] DIV_LAST   = 7'd64;

    localparam logic [5:0] PC_BODY  = 6'd0;
    localparam logic [5:0] PC_TAIL2 = 6'd13;
    localparam logic [5:0] PC_TAIL1 = 6'd18;
    localparam logic [5:0] PC_FIN   = 6'd24;

    function automatic logic [4:0] clip_count(input logic [4:0] c);
        clip_count = (c > FULL_COUNT) ? FULL_COUNT : c;
    endfunction

    function automatic logic [63:0] keep_bytes(input logic [63:0] v, input logic [4:0] n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (5'(i) < n) begin
                r[8*i +: 8] = v[8*i +: 8];
            end
        end
        keep_bytes = r;
    endfunction

    function automatic logic [63:0] rotl(input logic [63:0] v, input int s);
        rotl = (v << s) | (v >> (64 - s));
    endfunction

    // Sequence: body, k2 tail, k1 tail, then finalisation
    function automatic t_uop uc_rom(input logic [5:0] pc);
        case (pc)
            6'd0:  uc_rom = U_W_K1;
            6'd1:  uc_rom = U_MUL_A;
            6'd2:  uc_rom = U_ROT31;
            6'd3:  uc_rom = U_MUL_B;
            6'd4:  uc_rom = U_H1_BODY;
            6'd5:  uc_rom = U_H1_FIN5;
            6'd6:  uc_rom = U_W_K2;
            6'd7:  uc_rom = U_MUL_B;
            6'd8:  uc_rom = U_ROT33;
            6'd9:  uc_rom = U_MUL_A;
            6'd10: uc_rom = U_H2_BODY;
            6'd11: uc_rom = U_H2_FIN5;
            6'd12: uc_rom = U_RET;
            6'd13: uc_rom = U_W_K2;
            6'd14: uc_rom = U_MUL_B;
            6'd15: uc_rom = U_ROT33;
            6'd16: uc_rom = U_MUL_A;
            6'd17: uc_rom = U_H2_XOR;
            6'd18: uc_rom = U_W_K1;
            6'd19: uc_rom = U_MUL_A;
            6'd20: uc_rom = U_ROT31;
            6'd21: uc_rom = U_MUL_B;
            6'd22: uc_rom = U_H1_XOR;
            6'd23: uc_rom = U_RET;
            6'd24: uc_rom = U_LEN;
            6'd25: uc_rom = U_ADD_AB;
            6'd26: uc_rom = U_ADD_BA;
            6'd27: uc_rom = U_W_H1;
            6'd28: uc_rom = U_SHX;
            6'd29: uc_rom = U_MUL_FA;
            6'd30: uc_rom = U_SHX;
            6'd31: uc_rom = U_MUL_FB;
            6'd32: uc_rom = U_SHX;
            6'd33: uc_rom = U_H1_W;
            6'd34: uc_rom = U_W_H2;
            6'd35: uc_rom = U_SHX;
            6'd36: uc_rom = U_MUL_FA;
            6'd37: uc_rom = U_SHX;
            6'd38: uc_rom = U_MUL_FB;
            6'd39: uc_rom = U_SHX;
            6'd40: uc_rom = U_H2_W;
            6'd41: uc_rom = U_ADD_AB;
            6'd42: uc_rom = U_ADD_BA;
            6'd43: uc_rom = U_DIV;
            6'd44: uc_rom = U_END;
            default: uc_rom = U_NOP;
        endcase
    endfunction

endpackage

// ===== design/mmh_ctrl.sv =====
module mmh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  mmh_pkg::t_in_word i_in,
    output logic            o_in_ready,
    input  mmh_pkg::t_sts   i_sts,
    output mmh_pkg::t_cmd   o_cmd
);
    import mmh_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state     r_state;
    logic [5:0] r_pc;
    logic       r_last;
    logic [4:0] cnt;
    logic       full;
    logic       accept;
    t_uop       uop;
    logic       multi;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    assign cnt        = clip_count(i_in.byte_count);
    assign full       = (cnt == FULL_COUNT);
    assign uop        = uc_rom(r_pc);
    assign multi      = (uop inside {U_MUL_A, U_MUL_B, U_MUL_FA, U_MUL_FB, U_DIV});

    always_comb begin
        o_cmd.load = accept & (full | i_in.last_block);
        o_cmd.uop  = U_NOP;
        if (r_state == S_RUN) begin
            // hold the result back while the previous word is still unread
            if (!(uop == U_END && i_sts.out_busy)) begin
                o_cmd.uop = uop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= PC_BODY;
            r_last  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_last  <= i_in.last_block;
                        r_state <= S_RUN;
                        if (full) begin
                            r_pc <= PC_BODY;
                        end else if (cnt > 5'd8) begin
                            r_pc <= PC_TAIL2;
                        end else if (cnt != 5'd0) begin
                            r_pc <= PC_TAIL1;
                        end else begin
                            r_pc <= PC_FIN;
                        end
                    end
                end
                S_RUN: begin
                    if (multi) begin
                        if (i_sts.unit_done) begin
                            r_pc <= r_pc + 6'd1;
                        end
                    end else if (uop == U_RET) begin
                        if (r_last) begin
                            r_pc <= PC_FIN;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (uop == U_END) begin
                        if (!i_sts.out_busy) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_pc <= r_pc + 6'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/mmh_dpath.sv =====
module mmh_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mmh_pkg::t_cmd     i_cmd,
    input  mmh_pkg::t_in_word i_in,
    input  logic [31:0]       i_seed,
    input  logic [31:0]       i_bucket_count,
    input  logic              i_out_ready,
    output mmh_pkg::t_sts     o_sts,
    output logic              o_out_valid,
    output mmh_pkg::t_out_word o_out
);
    import mmh_pkg::*;

    logic [63:0] r_h1, r_h2, r_w, r_k1, r_k2;
    logic [63:0] r_p, r_acc;
    logic [31:0] r_len;
    logic        r_flag;
    logic        r_in_key;
    logic [6:0]  r_step;
    logic [31:0] r_rem, r_dvs, r_bkt;
    logic [63:0] r_dsh;
    logic        r_ov;

    logic [4:0]  cnt, cnt_hi;
    logic [31:0] base_len;
    logic [32:0] len_sum;
    logic        is_mul, is_div, done;
    logic [63:0] mconst;
    logic [31:0] ma, mb;
    logic [32:0] dtry;
    logic [32:0] rem_n;

    assign cnt      = clip_count(i_in.byte_count);
    assign cnt_hi   = (cnt > 5'd8) ? cnt - 5'd8 : 5'd0;
    assign base_len = r_in_key ? r_len : 32'd0;
    assign len_sum  = {1'b0, base_len} + {28'd0, cnt};

    assign is_mul = (i_cmd.uop inside {U_MUL_A, U_MUL_B, U_MUL_FA, U_MUL_FB});
    assign is_div = (i_cmd.uop == U_DIV);
    assign done   = (is_mul && r_step == MUL_LAST) || (is_div && r_step == DIV_LAST);

    always_comb begin
        case (i_cmd.uop)
            U_MUL_A:  mconst = C_MUL_A;
            U_MUL_B:  mconst = C_MUL_B;
            U_MUL_FA: mconst = C_FIN_A;
            U_MUL_FB: mconst = C_FIN_B;
            default:  mconst = C_MUL_A;
        endcase
        // low-half partial products only; the high cross terms fall off the top
        case (r_step[1:0])
            2'd0:    begin ma = r_w[31:0];  mb = mconst[31:0];  end
            2'd1:    begin ma = r_w[31:0];  mb = mconst[63:32]; end
            default: begin ma = r_w[63:32]; mb = mconst[31:0];  end
        endcase
    end

    assign dtry  = {r_rem, r_dsh[63]};
    assign rem_n = (dtry >= {1'b0, r_dvs}) ? dtry - {1'b0, r_dvs} : dtry;

    assign o_sts.unit_done = done;
    assign o_sts.out_busy  = r_ov & ~i_out_ready;
    assign o_out_valid     = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_ov     <= 1'b0;
            r_in_key <= 1'b0;
        end else begin
            r_step <= ((is_mul || is_div) && !done) ? r_step + 7'd1 : 7'd0;
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.load) begin
                r_in_key <= 1'b1;
            end
            if (i_cmd.uop == U_END) begin
                r_ov     <= 1'b1;
                r_in_key <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (!r_in_key) begin
                r_h1 <= {32'd0, i_seed};
                r_h2 <= {32'd0, i_seed};
            end
            r_k1   <= keep_bytes(i_in.block_low, cnt);
            r_k2   <= keep_bytes(i_in.block_high, cnt_hi);
            r_len  <= len_sum[31:0];
            r_flag <= (r_in_key & r_flag) | len_sum[32] | len_sum[31];
        end
        if (is_mul) begin
            r_p <= ma * mb;
            case (r_step[1:0])
                2'd1:    r_acc <= r_p;
                2'd2:    r_acc <= r_acc + {r_p[31:0], 32'd0};
                2'd3:    r_w   <= r_acc + {r_p[31:0], 32'd0};
                default: r_acc <= r_acc;
            endcase
        end
        if (is_div) begin
            if (r_step == 7'd0) begin
                r_rem <= '0;
                r_dsh <= r_h1;
                r_dvs <= i_bucket_count;
            end else begin
                r_rem <= rem_n[31:0];
                r_dsh <= {r_dsh[62:0], 1'b0};
                if (done) begin
                    r_bkt <= (r_dvs == 32'd0) ? 32'd0 : rem_n[31:0];
                end
            end
        end
        case (i_cmd.uop)
            U_W_K1:    r_w  <= r_k1;
            U_W_K2:    r_w  <= r_k2;
            U_W_H1:    r_w  <= r_h1;
            U_W_H2:    r_w  <= r_h2;
            U_ROT31:   r_w  <= rotl(r_w, 31);
            U_ROT33:   r_w  <= rotl(r_w, 33);
            U_SHX:     r_w  <= r_w ^ (r_w >> 33);
            U_H1_BODY: r_h1 <= rotl(r_h1 ^ r_w, 27) + r_h2;
            U_H1_FIN5: r_h1 <= (r_h1 << 2) + r_h1 + C_ADD_1;
            U_H2_BODY: r_h2 <= rotl(r_h2 ^ r_w, 31) + r_h1;
            U_H2_FIN5: r_h2 <= (r_h2 << 2) + r_h2 + C_ADD_2;
            U_H1_XOR:  r_h1 <= r_h1 ^ r_w;
            U_H2_XOR:  r_h2 <= r_h2 ^ r_w;
            U_LEN: begin
                r_h1 <= r_h1 ^ {32'd0, r_len};
                r_h2 <= r_h2 ^ {32'd0, r_len};
            end
            U_ADD_AB:  r_h1 <= r_h1 + r_h2;
            U_ADD_BA:  r_h2 <= r_h2 + r_h1;
            U_H1_W:    r_h1 <= r_w;
            U_H2_W:    r_h2 <= r_w;
            U_END: begin
                o_out.hash_low        <= r_h1;
                o_out.hash_high       <= r_h2;
                o_out.bucket_index    <= r_bkt;
                o_out.length_overflow <= r_flag;
            end
            // multiply and divide steps update their own registers above
            default: begin
            end
        endcase
    end

endmodule

// ===== design/murmur3_x64_128_bucket_hash.sv =====
// Channel   Dir  Handshake                      Payload
// in        in   i_in_valid / o_in_ready        i_in  (mmh_pkg::t_in_word)
// out       out  o_out_valid / i_out_ready      o_out (mmh_pkg::t_out_word)
// cfg       in   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One 32x32 multiplier is shared by every 64-bit product.
// A full block runs the body steps; a short last block runs the k2 tail (nine or more
// bytes) and the k1 tail, or the k1 tail alone (one to eight bytes), then finalisation.
// An empty last block goes straight to finalisation; the bucket remainder is bit-serial.
// Synchronous active-low reset; no clearing pass. Input ready is low while a word
// is worked on; the last step waits while the previous result is still unread.
module murmur3_x64_128_bucket_hash (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mmh_pkg::t_in_word   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mmh_pkg::t_out_word  o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import mmh_pkg::*;

    logic [31:0] r_seed;
    logic [31:0] r_bucket_count;
    t_cmd        cmd;
    t_sts        sts;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? r_bucket_count : r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed         <= '0;
            r_bucket_count <= 32'd1;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_bucket_count <= pwdata;
            end else begin
                r_seed <= pwdata;
            end
        end
    end

    mmh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mmh_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_in           (i_in),
        .i_seed         (r_seed),
        .i_bucket_count (r_bucket_count),
        .i_out_ready    (i_out_ready),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_out          (o_out)
    );

endmodule

// ===== design/mmh_checker.sv =====
`include "murmur3_x64_128_bucket_hash_macros.svh"

module mmh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input mmh_pkg::t_in_word  i_in,
    input logic               o_out_valid,
    input logic               i_out_ready
);
    import mmh_pkg::*;

    logic acc;
    logic takes_work;

    assign acc        = i_in_valid & o_in_ready;
    assign takes_work = (i_in.byte_count >= FULL_COUNT) | i_in.last_block;

    `MMH_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `MMH_ASSERT_NXT(a_busy_after_work, i_clk, i_rst_n, acc && takes_work, !o_in_ready)
    `MMH_ASSERT_NXT(a_drop_short, i_clk, i_rst_n, acc && !takes_work, o_in_ready)
    `MMH_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(!o_in_ready))

endmodule

bind murmur3_x64_128_bucket_hash mmh_checker u_mmh_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mmh_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam logic [2:0]  ADDR_SEED   = 3'd0;
    localparam logic [2:0]  ADDR_BUCKET = 3'd4;
    localparam int          SETTLE      = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    murmur3_x64_128_bucket_hash u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Model copy of the hash state and registers
    logic [31:0] mdl_seed;
    logic [31:0] mdl_buckets;
    logic        mdl_in_key;
    logic [63:0] mdl_h1;
    logic [63:0] mdl_h2;
    logic [31:0] mdl_len;
    logic        mdl_len_flag;

    t_out_word   hash_queue[$];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned hash_words;
    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned hold_off_cycles;

    function automatic logic [63:0] rot64(input logic [63:0] v, input int s);
        return (v << s) | (v >> (64 - s));
    endfunction

    function automatic logic [63:0] fmix(input logic [63:0] v);
        v = v ^ (v >> 33);
        v = v * C_FIN_A;
        v = v ^ (v >> 33);
        v = v * C_FIN_B;
        v = v ^ (v >> 33);
        return v;
    endfunction

    function automatic logic [63:0] mix_k1(input logic [63:0] k);
        k = k * C_MUL_A;
        k = rot64(k, 31);
        return k * C_MUL_B;
    endfunction

    function automatic logic [63:0] mix_k2(input logic [63:0] k);
        k = k * C_MUL_B;
        k = rot64(k, 33);
        return k * C_MUL_A;
    endfunction

    function automatic logic [63:0] low_bytes(input logic [63:0] v, input int n);
        if (n >= 8) return v;
        return v & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    // Advance the hash state by one word; returns 1 when a hash comes out
    function automatic logic hash_word(input t_in_word w, output t_out_word r);
        int          cnt;
        logic [31:0] next_len;
        logic [63:0] a;
        logic [63:0] b;
        r = '0;
        cnt = (w.byte_count > 5'd16) ? 16 : int'(w.byte_count);
        if (!w.last_block && cnt < 16) return 1'b0;
        if (!mdl_in_key) begin
            mdl_h1 = {32'd0, mdl_seed};
            mdl_h2 = {32'd0, mdl_seed};
            mdl_len = '0;
            mdl_len_flag = 1'b0;
            mdl_in_key = 1'b1;
        end
        if (cnt == 16) begin
            mdl_h1 = mdl_h1 ^ mix_k1(w.block_low);
            mdl_h1 = rot64(mdl_h1, 27) + mdl_h2;
            mdl_h1 = mdl_h1 * 64'd5 + C_ADD_1;
            mdl_h2 = mdl_h2 ^ mix_k2(w.block_high);
            mdl_h2 = rot64(mdl_h2, 31) + mdl_h1;
            mdl_h2 = mdl_h2 * 64'd5 + C_ADD_2;
        end else begin
            if (cnt > 8) mdl_h2 = mdl_h2 ^ mix_k2(low_bytes(w.block_high, cnt - 8));
            if (cnt > 0) mdl_h1 = mdl_h1 ^ mix_k1(low_bytes(w.block_low, cnt));
        end
        next_len = mdl_len + 32'(cnt);
        if (next_len < mdl_len || next_len > 32'h7fffffff) mdl_len_flag = 1'b1;
        mdl_len = next_len;
        if (!w.last_block) return 1'b0;
        a = mdl_h1 ^ {32'd0, mdl_len};
        b = mdl_h2 ^ {32'd0, mdl_len};
        a = a + b;
        b = b + a;
        a = fmix(a);
        b = fmix(b);
        a = a + b;
        b = b + a;
        mdl_h1 = a;
        mdl_h2 = b;
        mdl_in_key = 1'b0;
        r.hash_low = a;
        r.hash_high = b;
        r.bucket_index = (mdl_buckets == 0) ? 32'd0 : 32'(a % {32'd0, mdl_buckets});
        r.length_overflow = mdl_len_flag;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: check each word taken, then choose ready for the next cycle
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (hash_queue.size() == 0) begin
                    report_mismatch("unexpected word hash_low", o_out.hash_low, '0);
                end else begin
                    want = hash_queue.pop_front();
                    if (o_out.hash_low !== want.hash_low)
                        report_mismatch("hash_low", o_out.hash_low, want.hash_low);
                    if (o_out.hash_high !== want.hash_high)
                        report_mismatch("hash_high", o_out.hash_high, want.hash_high);
                    if (o_out.bucket_index !== want.bucket_index)
                        report_mismatch("bucket_index", 64'(o_out.bucket_index),
                                        64'(want.bucket_index));
                    if (o_out.length_overflow !== want.length_overflow)
                        report_mismatch("length_overflow", 64'(o_out.length_overflow),
                                        64'(want.length_overflow));
                end
            end
            if (hold_off_cycles != 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one word and hold it until taken; a typed expectation overrides the model
    task automatic send_word(input t_in_word w, input logic typed, input t_out_word typed_val);
        t_out_word r;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        if (hash_word(w, r)) hash_queue.push_back(typed ? typed_val : r);
        if (w.last_block || w.byte_count >= 5'd16) hash_words++;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (hash_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SEED) mdl_seed = data;
        else mdl_buckets = data;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_key;
        t_in_word  w;
        t_out_word none;
        int        nfull;
        none = '0;
        nfull = ($urandom_range(19) == 0) ? $urandom_range(12) : $urandom_range(3);
        for (int i = 0; i <= nfull; i++) begin
            // drop in an ignored short word now and then
            if ($urandom_range(9) == 0) begin
                w.block_low = rand64();
                w.block_high = rand64();
                w.byte_count = 5'($urandom_range(15));
                w.last_block = 1'b0;
                send_word(w, 1'b0, none);
            end
            w.block_low = rand64();
            w.block_high = rand64();
            w.last_block = (i == nfull);
            if (i == nfull)
                w.byte_count = ($urandom_range(7) == 0) ? 5'($urandom_range(31))
                                                        : 5'($urandom_range(16));
            else
                w.byte_count = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17)) : 5'd16;
            send_word(w, 1'b0, none);
        end
    endtask

    typedef struct {
        t_in_word  w;
        logic      typed;
        t_out_word want;
    } t_row;

    t_row rows[$];

    function automatic t_row row(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [4:0] cnt, input logic last);
        t_row r;
        r.w.block_low = lo;
        r.w.block_high = hi;
        r.w.byte_count = cnt;
        r.w.last_block = last;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    initial begin
        t_row        r0;
        int unsigned phase_goal;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        cycle_count = 0;
        hash_words = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        mdl_seed = '0;
        mdl_buckets = 32'd1;
        mdl_in_key = 1'b0;
        mdl_h1 = '0;
        mdl_h2 = '0;
        mdl_len = '0;
        mdl_len_flag = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty key under reset seed hashes to zero
        r0 = row('0, '0, 5'd0, 1'b1);
        r0.typed = 1'b1;
        rows.push_back(r0);
        rows.push_back(row('1, '1, 5'd16, 1'b1));
        rows.push_back(row('0, '0, 5'd16, 1'b0));
        rows.push_back(row('1, '1, 5'd1, 1'b1));
        rows.push_back(row('1, '1, 5'd8, 1'b1));
        rows.push_back(row('1, '1, 5'd9, 1'b1));
        rows.push_back(row('1, '0, 5'd5, 1'b0));
        rows.push_back(row('1, '1, 5'd15, 1'b1));
        rows.push_back(row('1, '1, 5'd17, 1'b0));
        rows.push_back(row('1, '1, 5'd31, 1'b1));
        rows.push_back(row(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16, 1'b0));
        rows.push_back(row(64'h8000000000000001, 64'h8000000000000001, 5'd16, 1'b0));
        rows.push_back(row(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd12, 1'b1));
        rows.push_back(row('0, '0, 5'd0, 1'b1));

        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    reg_write(ADDR_SEED, 32'hffffffff);
                    reg_write(ADDR_BUCKET, 32'hffffffff);
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    reg_write(ADDR_SEED, $urandom);
                    reg_write(ADDR_BUCKET, 32'd0);
                    send_idle_pct = 46;
                    recv_stall_pct = 0;
                end
                2: begin
                    reg_write(ADDR_SEED, 32'd1);
                    reg_write(ADDR_BUCKET, 32'd7);
                    send_idle_pct = 0;
                    recv_stall_pct = 46;
                end
                3: begin
                    reg_write(ADDR_SEED, 32'd0);
                    reg_write(ADDR_BUCKET, 32'd1);
                    send_idle_pct = 34;
                    recv_stall_pct = 34;
                end
                default: begin
                    reg_write(ADDR_SEED, $urandom);
                    reg_write(ADDR_BUCKET, $urandom_range(32'hffffffff, 1));
                    send_idle_pct = 0;
                    recv_stall_pct = 20;
                    // hold the result side off so the block backs up
                    hold_off_cycles = 3000;
                end
            endcase
            phase_goal = hash_words + 315;
            while (hash_words < phase_goal) send_key();
            drain();
        end

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
